[rtl/tfp_pkg.sv]
// shared types and constants for the touch frame to pointer block
// no dependencies; every other file imports this package
package tfp_pkg;

  localparam int unsigned MAX_POINTS = 15;
  localparam int unsigned BAD_LIMIT  = 10;
  localparam int unsigned FULL_SCALE = 32767;
  localparam int unsigned X_SPAN     = 800;
  localparam int unsigned Y_SPAN     = 480;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SIZE_W  = 8;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned NPTS_W  = 4;
  localparam int unsigned BAD_W   = 4;
  localparam int unsigned ABS_W   = 15;
  localparam int unsigned BTN_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // scaling: raw * FULL_SCALE / span = ((raw * FULL_SCALE) >> PRE_SHIFT) / (span >> PRE_SHIFT)
  localparam int unsigned PRE_SHIFT   = 5;
  localparam int unsigned X_DIV       = X_SPAN >> PRE_SHIFT;
  localparam int unsigned Y_DIV       = Y_SPAN >> PRE_SHIFT;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned X_RECIP     = (1 << RECIP_SHIFT) / X_DIV;
  localparam int unsigned Y_RECIP     = (1 << RECIP_SHIFT) / Y_DIV;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned X_RAW_W     = $clog2(X_SPAN + 1);
  localparam int unsigned Y_RAW_W     = $clog2(Y_SPAN + 1);
  localparam int unsigned X_P_W       = X_RAW_W + ABS_W;
  localparam int unsigned Y_P_W       = Y_RAW_W + ABS_W;
  localparam int unsigned X_N_W       = X_P_W - PRE_SHIFT;
  localparam int unsigned Y_N_W       = Y_P_W - PRE_SHIFT;
  localparam int unsigned X_PR_W      = X_N_W + RECIP_W;
  localparam int unsigned Y_PR_W      = Y_N_W + RECIP_W;
  localparam int unsigned Q_W         = ABS_W + 1;

  // job queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_IDLE  = 2'd0,
    OP_POINT = 2'd1,
    OP_PROBE = 2'd2
  } op_t;

  typedef enum logic [BTN_W-1:0] {
    BTN_MOVE  = 2'd0,
    BTN_LEFT  = 2'd1,
    BTN_RIGHT = 2'd2
  } button_t;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_FAULT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_PRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LIMIT = 2'd2;

  localparam logic [SIZE_W-1:0]  RST_RIGHT_PRESS = 8'd80;
  localparam logic [SIZE_W-1:0]  RST_LEFT_PRESS  = 8'd40;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_LIMIT = 8'd10;

  typedef struct packed {
    logic [SIZE_W-1:0]  right_press;
    logic [SIZE_W-1:0]  left_press;
    logic [LEVEL_W-1:0] level_limit;
  } cfg_t;

  typedef struct packed {
    logic               fault;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  size;
    logic [LEVEL_W-1:0] level;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

endpackage

[rtl/tfp_if.sv]
// request channel interfaces: touch item input and pointer result output
// depends on tfp_pkg
interface tfp_in_if;
  import tfp_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic               probe_ack;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [SIZE_W-1:0]  point_size;
  logic [NPTS_W-1:0]  frame_points;
  logic               last_point;

  modport source (output valid, op, probe_ack, point_x, point_y, point_size, frame_points,
                  last_point, input ready);
  modport sink (input valid, op, probe_ack, point_x, point_y, point_size, frame_points,
                last_point, output ready);
endinterface

interface tfp_out_if;
  import tfp_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [ABS_W-1:0]   abs_x;
  logic [ABS_W-1:0]   abs_y;
  logic [BTN_W-1:0]   button;
  logic [SIZE_W-1:0]  contact_size;
  logic [LEVEL_W-1:0] touch_level;

  modport source (output valid, kind, abs_x, abs_y, button, contact_size, touch_level,
                  input ready);
  modport sink (input valid, kind, abs_x, abs_y, button, contact_size, touch_level,
                output ready);
endinterface

[rtl/tfp_front.sv]
// front end: takes input requests, tracks panel state and frame best point,
// and pushes one job per finished frame; depends on tfp_pkg and tfp_if
module tfp_front (
  input  logic           clk,
  input  logic           rst_n,
  tfp_in_if.sink         in_ch,
  input  tfp_pkg::cfg_t  cfg,
  input  logic           q_full,
  output tfp_pkg::q_wr_t q_wr
);
  import tfp_pkg::*;

  logic               panel_ok_r, panel_ok_nxt;
  logic               frame_start_r, frame_start_nxt;
  logic [LEVEL_W-1:0] activity_r, activity_nxt;
  logic [SIZE_W-1:0]  best_size_r, best_size_nxt;
  logic [COORD_W-1:0] best_x_r, best_x_nxt;
  logic [COORD_W-1:0] best_y_r, best_y_nxt;
  logic [BAD_W-1:0]   bad_r, bad_nxt;

  logic               accept;
  logic               is_bad;
  logic               take;
  logic [SIZE_W-1:0]  cand_size;
  logic [COORD_W-1:0] cand_x;
  logic [COORD_W-1:0] cand_y;
  logic [BAD_W-1:0]   cand_bad;
  logic [LEVEL_W:0]   level_sum;
  logic [LEVEL_W-1:0] level_new;
  logic               fault;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    is_bad    = (in_ch.point_x == '1) && (in_ch.point_y == '1) && (in_ch.point_size == '1);
    take      = frame_start_r || (in_ch.point_size > best_size_r);
    cand_size = take ? in_ch.point_size : best_size_r;
    cand_x    = take ? in_ch.point_x : best_x_r;
    cand_y    = take ? in_ch.point_y : best_y_r;
    cand_bad  = (is_bad && bad_r != '1) ? bad_r + BAD_W'(1) : bad_r;
    level_sum = {1'b0, activity_r} + (LEVEL_W+1)'(1);
    level_new = (level_sum > {1'b0, cfg.level_limit}) ? cfg.level_limit
                                                      : level_sum[LEVEL_W-1:0];
    fault     = (in_ch.frame_points == NPTS_W'(MAX_POINTS)) && (cand_bad > BAD_W'(BAD_LIMIT));

    panel_ok_nxt    = panel_ok_r;
    frame_start_nxt = frame_start_r;
    activity_nxt    = activity_r;
    best_size_nxt   = best_size_r;
    best_x_nxt      = best_x_r;
    best_y_nxt      = best_y_r;
    bad_nxt         = bad_r;
    q_wr.push       = 1'b0;
    q_wr.job.fault  = fault;
    q_wr.job.x      = cand_x;
    q_wr.job.y      = cand_y;
    q_wr.job.size   = cand_size;
    q_wr.job.level  = level_new;

    if (accept) begin
      unique case (in_ch.op)
        OP_PROBE: begin
          panel_ok_nxt    = in_ch.probe_ack;
          frame_start_nxt = 1'b1;
          best_size_nxt   = '0;
          best_x_nxt      = '0;
          best_y_nxt      = '0;
          bad_nxt         = '0;
        end
        OP_IDLE: begin
          if (panel_ok_r && activity_r != '0) begin
            activity_nxt = activity_r - LEVEL_W'(1);
          end
        end
        OP_POINT: begin
          if (panel_ok_r) begin
            if (in_ch.last_point) begin
              q_wr.push       = 1'b1;
              activity_nxt    = level_new;
              frame_start_nxt = 1'b1;
              best_size_nxt   = '0;
              best_x_nxt      = '0;
              best_y_nxt      = '0;
              bad_nxt         = '0;
              if (fault) begin
                panel_ok_nxt = 1'b0;
              end
            end else begin
              frame_start_nxt = 1'b0;
              best_size_nxt   = cand_size;
              best_x_nxt      = cand_x;
              best_y_nxt      = cand_y;
              bad_nxt         = cand_bad;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_ok_r    <= 1'b0;
      frame_start_r <= 1'b1;
      activity_r    <= '0;
      best_size_r   <= '0;
      best_x_r      <= '0;
      best_y_r      <= '0;
      bad_r         <= '0;
    end else begin
      panel_ok_r    <= panel_ok_nxt;
      frame_start_r <= frame_start_nxt;
      activity_r    <= activity_nxt;
      best_size_r   <= best_size_nxt;
      best_x_r      <= best_x_nxt;
      best_y_r      <= best_y_nxt;
      bad_r         <= bad_nxt;
    end
  end

`ifndef SYNTH
  a_fault_drops_panel: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push && q_wr.job.fault |=> !panel_ok_r)
    else $error("fault frame did not drop panel ok");

  a_level_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> q_wr.job.level <= cfg.level_limit)
    else $error("touch level above limit");

  a_push_restarts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |=> frame_start_r && bad_r == '0 && best_size_r == '0)
    else $error("frame not cleared after report");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_wr.push)
    else $error("job pushed into full queue");
`endif

endmodule

[rtl/tfp_queue.sv]
// small job queue between front and back
// depends on tfp_pkg
module tfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  tfp_pkg::q_wr_t wr,
  output logic           full,
  input  logic           pop,
  output tfp_pkg::q_rd_t rd
);
  import tfp_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign rd.valid = (count_r != '0);
  assign rd.job   = mem_r[rd_ptr_r];
  assign do_push  = wr.push && !full;
  assign do_pop   = pop && rd.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr.job;
    end
  end

endmodule

[rtl/tfp_back.sv]
// back end: scales the kept point, picks the button and drives the result register
// two pipeline stages plus output register; depends on tfp_pkg and tfp_if
module tfp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tfp_pkg::q_rd_t q_rd,
  output logic           pop,
  input  tfp_pkg::cfg_t  cfg,
  tfp_out_if.source      out_ch
);
  import tfp_pkg::*;

  logic adv;

  // stage 1: raw * full scale
  logic               s1_v_r;
  logic               s1_fault_r, s1_sat_x_r, s1_sat_y_r;
  logic [X_P_W-1:0]   s1_px_r;
  logic [Y_P_W-1:0]   s1_py_r;
  logic [SIZE_W-1:0]  s1_size_r;
  logic [LEVEL_W-1:0] s1_level_r;
  logic [BTN_W-1:0]   s1_btn_r;
  logic [BTN_W-1:0]   btn;

  // stage 2: reciprocal multiply
  logic               s2_v_r;
  logic               s2_fault_r, s2_sat_x_r, s2_sat_y_r;
  logic [X_N_W-1:0]   s2_nx_r;
  logic [Y_N_W-1:0]   s2_ny_r;
  logic [Q_W-1:0]     s2_qx_r;
  logic [Q_W-1:0]     s2_qy_r;
  logic [SIZE_W-1:0]  s2_size_r;
  logic [LEVEL_W-1:0] s2_level_r;
  logic [BTN_W-1:0]   s2_btn_r;
  logic [X_N_W-1:0]   nx;
  logic [Y_N_W-1:0]   ny;
  logic [X_PR_W-1:0]  prod_x;
  logic [Y_PR_W-1:0]  prod_y;

  // stage 3: remainder correction into the output register
  logic               out_v_r;
  logic               out_kind_r;
  logic [ABS_W-1:0]   out_x_r, out_y_r;
  logic [BTN_W-1:0]   out_btn_r;
  logic [SIZE_W-1:0]  out_size_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [X_N_W-1:0]   rem_x;
  logic [Y_N_W-1:0]   rem_y;
  logic [Q_W-1:0]     qx, qy;
  logic [ABS_W-1:0]   abs_x, abs_y;

  assign adv = !out_v_r || out_ch.ready;
  assign pop = adv;

  always_comb begin
    if (q_rd.job.fault) begin
      btn = BTN_MOVE;
    end else if (q_rd.job.size > cfg.right_press) begin
      btn = BTN_RIGHT;
    end else if (q_rd.job.size > cfg.left_press) begin
      btn = BTN_LEFT;
    end else begin
      btn = BTN_MOVE;
    end
  end

  assign nx     = s1_px_r[X_P_W-1:PRE_SHIFT];
  assign ny     = s1_py_r[Y_P_W-1:PRE_SHIFT];
  assign prod_x = X_PR_W'(nx) * X_PR_W'(X_RECIP);
  assign prod_y = Y_PR_W'(ny) * Y_PR_W'(Y_RECIP);

  // reciprocal estimate is low by at most one
  always_comb begin
    rem_x = s2_nx_r - X_N_W'(X_N_W'(s2_qx_r) * X_N_W'(X_DIV));
    rem_y = s2_ny_r - Y_N_W'(Y_N_W'(s2_qy_r) * Y_N_W'(Y_DIV));
    qx    = (rem_x >= X_N_W'(X_DIV)) ? s2_qx_r + Q_W'(1) : s2_qx_r;
    qy    = (rem_y >= Y_N_W'(Y_DIV)) ? s2_qy_r + Q_W'(1) : s2_qy_r;
    if (s2_fault_r) begin
      abs_x = '0;
      abs_y = '0;
    end else begin
      abs_x = s2_sat_x_r ? ABS_W'(FULL_SCALE) : qx[ABS_W-1:0];
      abs_y = s2_sat_y_r ? ABS_W'(FULL_SCALE) : qy[ABS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= q_rd.valid;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fault_r <= q_rd.job.fault;
      s1_sat_x_r <= q_rd.job.x > COORD_W'(X_SPAN);
      s1_sat_y_r <= q_rd.job.y > COORD_W'(Y_SPAN);
      s1_px_r    <= X_P_W'(q_rd.job.x[X_RAW_W-1:0]) * X_P_W'(FULL_SCALE);
      s1_py_r    <= Y_P_W'(q_rd.job.y[Y_RAW_W-1:0]) * Y_P_W'(FULL_SCALE);
      s1_size_r  <= q_rd.job.size;
      s1_level_r <= q_rd.job.level;
      s1_btn_r   <= btn;

      s2_fault_r <= s1_fault_r;
      s2_sat_x_r <= s1_sat_x_r;
      s2_sat_y_r <= s1_sat_y_r;
      s2_nx_r    <= nx;
      s2_ny_r    <= ny;
      s2_qx_r    <= prod_x[RECIP_SHIFT +: Q_W];
      s2_qy_r    <= prod_y[RECIP_SHIFT +: Q_W];
      s2_size_r  <= s1_size_r;
      s2_level_r <= s1_level_r;
      s2_btn_r   <= s1_btn_r;

      out_kind_r  <= s2_fault_r ? KIND_FAULT : KIND_REPORT;
      out_x_r     <= abs_x;
      out_y_r     <= abs_y;
      out_btn_r   <= s2_btn_r;
      out_size_r  <= s2_size_r;
      out_level_r <= s2_level_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.abs_x        = out_x_r;
  assign out_ch.abs_y        = out_y_r;
  assign out_ch.button       = out_btn_r;
  assign out_ch.contact_size = out_size_r;
  assign out_ch.touch_level  = out_level_r;

endmodule

[rtl/touch_frame_to_pointer.sv]
// Touch frame to pointer: one input request per touch point, idle tick or panel
// probe, taken at one per cycle whenever the four-entry job queue has room. The
// front end updates the frame and panel state in the cycle a request is taken;
// the point marked last queues a job, and the back end turns it into a pointer
// or fault result through three register stages (two multiplier stages and a
// remainder correction into the output register). A stalled result stalls the
// back pipeline only; the front keeps taking requests until the queue fills.
// Configuration writes take effect in the cycle after the write.
// No clearing pass is needed after reset.
// Depends on tfp_pkg, tfp_if, tfp_front, tfp_queue and tfp_back.
module touch_frame_to_pointer (
  input  logic                             clk,
  input  logic                             rst_n,
  tfp_in_if.sink                           in_ch,
  tfp_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [tfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tfp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tfp_pkg::*;

  cfg_t  cfg_r;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.right_press <= RST_RIGHT_PRESS;
      cfg_r.left_press  <= RST_LEFT_PRESS;
      cfg_r.level_limit <= RST_LEVEL_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RIGHT_PRESS: cfg_r.right_press <= cfg_data;
        CFG_LEFT_PRESS:  cfg_r.left_press  <= cfg_data;
        CFG_LEVEL_LIMIT: cfg_r.level_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  tfp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  tfp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .rd    (q_rd)
  );

  tfp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .cfg    (cfg_r),
    .out_ch (out_ch)
  );

endmodule
